// ===== hw/rtl/pcrrq_pkg.sv =====
// shared types, field widths and codes of the per-client round-robin queue
package pcrrq_pkg;

    localparam int CLIENT_W  = 10;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;

    localparam int DEF_MAX_LANES    = 16;
    localparam int DEF_LANE_DEPTH   = 16;
    localparam int DEF_SHARED_DEPTH = 64;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_RR   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_FULL      = 2'd2,
        ST_NO_LANE   = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/pcrrq_req_if.sv =====
// request channel: operation, client id and payload
interface pcrrq_req_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [pcrrq_pkg::CLIENT_W-1:0]   client;
    logic [pcrrq_pkg::PAYLOAD_W-1:0]  payload;

    modport source (output valid, output op, output client, output payload, input ready);
    modport sink   (input valid, input op, input client, input payload, output ready);
endinterface

// ===== hw/rtl/pcrrq_rsp_if.sv =====
// response channel: popped item, empty flag and status
interface pcrrq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             out_valid;
    logic [pcrrq_pkg::CLIENT_W-1:0]   out_client;
    logic [pcrrq_pkg::PAYLOAD_W-1:0]  out_payload;
    logic                             now_empty;
    logic [pcrrq_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output out_valid, output out_client, output out_payload,
                    output now_empty, output status, input ready);
    modport sink   (input valid, input out_valid, input out_client, input out_payload,
                    input now_empty, input status, output ready);
endinterface

// ===== hw/rtl/pcrrq_ram.sv =====
// generic single-write, single-read ram with registered read data
module pcrrq_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pcrrq_lane_pick.sv =====
// rotating priority pick of the next non-empty lane
module pcrrq_lane_pick #(
    parameter int MAX_LANES = pcrrq_pkg::DEF_MAX_LANES,
    localparam int LW = $clog2(MAX_LANES)
) (
    input  logic [MAX_LANES-1:0] i_busy,
    input  logic [LW-1:0]        i_ptr,
    output logic                 o_found,
    output logic [LW-1:0]        o_idx
);

    logic [MAX_LANES-1:0] upper;
    logic [LW-1:0]        idx_upper;
    logic [LW-1:0]        idx_all;

    always_comb begin
        upper     = '0;
        idx_upper = '0;
        idx_all   = '0;
        for (int i = 0; i < MAX_LANES; i++) begin
            upper[i] = i_busy[i] && (LW'(i) >= i_ptr);
        end
        for (int i = MAX_LANES - 1; i >= 0; i--) begin
            if (upper[i]) begin
                idx_upper = LW'(i);
            end
            if (i_busy[i]) begin
                idx_all = LW'(i);
            end
        end
    end

    // lanes at or past the pointer first, then wrap to the lowest one
    assign o_found = |i_busy;
    assign o_idx   = (|upper) ? idx_upper : idx_all;

endmodule

// ===== hw/rtl/per_client_round_robin_queue.sv =====
// top level of the per-client round-robin request queue
//
// Requests arrive on i_req (op, client, payload); one response per request leaves
// on o_rsp (out_valid, out_client, out_payload, now_empty, status). A transfer
// happens when valid and ready are both high.
// i_cfg_we/i_cfg_data write the mode (0 shared fifo, 1 per-client lanes) and clear
// the whole store; write only while no request is in flight.
// One request is worked on at a time. Steps from request transfer to response valid:
//   fifo push goes straight to the result, fifo pop reads the entry ram, lane push
//   does a lane state ram read-modify-write, lane pop reads lane state, then entry.
// i_req.ready returns high together with the response valid, so a new request is
// taken only after the last response has gone into the output register.
// The response sits in an output register; a stalled receiver holds it there while
// the next request is worked on, and only the following load waits for the transfer.
// Reset (synchronous, active low) selects fifo mode and empties all queues; no
// clearing pass is needed since entries are only read behind nonzero fill counts.
module per_client_round_robin_queue #(
    parameter int MAX_LANES    = pcrrq_pkg::DEF_MAX_LANES,
    parameter int LANE_DEPTH   = pcrrq_pkg::DEF_LANE_DEPTH,
    parameter int SHARED_DEPTH = pcrrq_pkg::DEF_SHARED_DEPTH,
    parameter int PAYLOAD_BITS = pcrrq_pkg::DEF_PAYLOAD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    pcrrq_req_if.sink   i_req,
    pcrrq_rsp_if.source o_rsp
);

    localparam int CW     = pcrrq_pkg::CLIENT_W;
    localparam int LW     = $clog2(MAX_LANES);
    localparam int LCW    = $clog2(MAX_LANES + 1);
    localparam int LPW    = $clog2(LANE_DEPTH);
    localparam int LFW    = $clog2(LANE_DEPTH + 1);
    localparam int LSW    = 2 * LPW + LFW;
    localparam int SPW    = $clog2(SHARED_DEPTH);
    localparam int SFW    = $clog2(SHARED_DEPTH + 1);
    localparam int EW     = CW + PAYLOAD_BITS;
    localparam int EDEPTH = (SHARED_DEPTH > MAX_LANES * LANE_DEPTH) ?
                            SHARED_DEPTH : MAX_LANES * LANE_DEPTH;
    localparam int EAW    = $clog2(EDEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LANE,
        S_ENTRY,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic                   r_mode;
    logic [LCW-1:0]         r_lane_cnt;
    logic [LW-1:0]          r_rr_ptr;
    logic [MAX_LANES-1:0]   r_busy;
    logic [CW-1:0]          r_tag [MAX_LANES];
    logic [SPW-1:0]         r_sh_head;
    logic [SPW-1:0]         r_sh_tail;
    logic [SFW-1:0]         r_sh_fill;

    logic                   r_op;
    logic [CW-1:0]          r_client;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [LW-1:0]          r_lane;
    logic                   r_new_lane;

    logic                   r_res_valid;
    logic [CW-1:0]          r_res_client;
    logic [PAYLOAD_BITS-1:0] r_res_pay;
    pcrrq_pkg::t_status     r_res_status;

    logic                   r_o_vld;
    logic                   r_o_outv;
    logic [CW-1:0]          r_o_client;
    logic [pcrrq_pkg::PAYLOAD_W-1:0] r_o_pay;
    logic                   r_o_empty;
    pcrrq_pkg::t_status     r_o_status;

    logic                   hit_any;
    logic [LW-1:0]          hit_idx;
    logic                   pick_found;
    logic [LW-1:0]          pick_idx;
    logic [LW-1:0]          sel_lane;
    logic [LCW-1:0]         rr_inc;
    logic                   lanes_full;
    logic                   sh_full;
    logic [PAYLOAD_BITS-1:0] in_pay;

    logic                   lst_we;
    logic [LSW-1:0]         lst_wdata;
    logic [LW-1:0]          lst_raddr;
    logic [LSW-1:0]         lst_rdata;
    logic [LPW-1:0]         ls_head;
    logic [LPW-1:0]         ls_tail;
    logic [LFW-1:0]         ls_fill;
    logic [LPW-1:0]         ls_head_inc;
    logic [LPW-1:0]         ls_tail_inc;
    logic                   ls_full;
    logic [EAW-1:0]         lane_base;

    logic                   ent_we;
    logic [EAW-1:0]         ent_waddr;
    logic [EW-1:0]          ent_wdata;
    logic [EAW-1:0]         ent_raddr;
    logic [EW-1:0]          ent_rdata;

    logic                   accept;
    logic                   out_load;

    assign accept   = (r_state == S_IDLE) && i_req.valid;
    assign out_load = (r_state == S_DONE) && (!r_o_vld || o_rsp.ready);
    assign in_pay   = PAYLOAD_BITS'(i_req.payload);
    assign sh_full  = (r_sh_fill == SFW'(SHARED_DEPTH));
    assign lanes_full = (r_lane_cnt == LCW'(MAX_LANES));

    // client lookup over the lanes in use
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = MAX_LANES - 1; i >= 0; i--) begin
            if ((LCW'(i) < r_lane_cnt) && (r_tag[i] == i_req.client)) begin
                hit_any = 1'b1;
                hit_idx = LW'(i);
            end
        end
    end

    pcrrq_lane_pick #(
        .MAX_LANES (MAX_LANES)
    ) u_pick (
        .i_busy  (r_busy),
        .i_ptr   (r_rr_ptr),
        .o_found (pick_found),
        .o_idx   (pick_idx)
    );

    assign rr_inc = LCW'(pick_idx) + LCW'(1);

    always_comb begin
        if (i_req.op == pcrrq_pkg::OP_POP) begin
            sel_lane = pick_idx;
        end else if (hit_any) begin
            sel_lane = hit_idx;
        end else begin
            sel_lane = r_lane_cnt[LW-1:0];
        end
    end

    // lane state: head, tail, fill; a freshly taken lane reads as empty
    assign lst_raddr   = sel_lane;
    assign ls_head     = r_new_lane ? '0 : lst_rdata[LSW-1 -: LPW];
    assign ls_tail     = r_new_lane ? '0 : lst_rdata[LFW+LPW-1 -: LPW];
    assign ls_fill     = r_new_lane ? '0 : lst_rdata[LFW-1:0];
    assign ls_head_inc = (ls_head == LPW'(LANE_DEPTH - 1)) ? '0 : ls_head + LPW'(1);
    assign ls_tail_inc = (ls_tail == LPW'(LANE_DEPTH - 1)) ? '0 : ls_tail + LPW'(1);
    assign ls_full     = (ls_fill == LFW'(LANE_DEPTH));
    assign lane_base   = EAW'(r_lane) * EAW'(LANE_DEPTH);

    always_comb begin
        lst_we    = 1'b0;
        lst_wdata = {ls_head, ls_tail, ls_fill};
        if (r_state == S_LANE) begin
            if (r_op == pcrrq_pkg::OP_PUSH) begin
                lst_we    = !ls_full;
                lst_wdata = {ls_head, ls_tail_inc, ls_fill + LFW'(1)};
            end else begin
                lst_we    = 1'b1;
                lst_wdata = {ls_head_inc, ls_tail, ls_fill - LFW'(1)};
            end
        end
    end

    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = EAW'(r_sh_tail);
        ent_wdata = {i_req.client, in_pay};
        ent_raddr = EAW'(r_sh_head);
        if (accept && (r_mode == pcrrq_pkg::MODE_FIFO) && (i_req.op == pcrrq_pkg::OP_PUSH)) begin
            ent_we = !sh_full;
        end
        if (r_state == S_LANE) begin
            ent_raddr = lane_base + EAW'(ls_head);
            ent_waddr = lane_base + EAW'(ls_tail);
            ent_wdata = {r_client, r_pay};
            ent_we    = (r_op == pcrrq_pkg::OP_PUSH) && !ls_full;
        end
    end

    pcrrq_ram #(
        .W (LSW),
        .D (MAX_LANES)
    ) u_lane_state (
        .i_clk   (i_clk),
        .i_we    (lst_we),
        .i_waddr (r_lane),
        .i_wdata (lst_wdata),
        .i_raddr (lst_raddr),
        .o_rdata (lst_rdata)
    );

    pcrrq_ram #(
        .W (EW),
        .D (EDEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= pcrrq_pkg::MODE_FIFO;
            r_lane_cnt <= '0;
            r_rr_ptr   <= '0;
            r_busy     <= '0;
            r_sh_head  <= '0;
            r_sh_tail  <= '0;
            r_sh_fill  <= '0;
            r_o_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode     <= i_cfg_data;
                r_lane_cnt <= '0;
                r_rr_ptr   <= '0;
                r_busy     <= '0;
                r_sh_head  <= '0;
                r_sh_tail  <= '0;
                r_sh_fill  <= '0;
            end
            if (o_rsp.ready && !out_load) begin
                r_o_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op         <= i_req.op;
                        r_client     <= i_req.client;
                        r_pay        <= in_pay;
                        r_lane       <= sel_lane;
                        r_new_lane   <= 1'b0;
                        r_res_valid  <= 1'b0;
                        r_res_client <= '0;
                        r_res_pay    <= '0;
                        r_res_status <= pcrrq_pkg::ST_OK;
                        if (r_mode == pcrrq_pkg::MODE_FIFO) begin
                            if (i_req.op == pcrrq_pkg::OP_PUSH) begin
                                if (sh_full) begin
                                    r_res_status <= pcrrq_pkg::ST_FULL;
                                end else begin
                                    r_sh_tail <= (r_sh_tail == SPW'(SHARED_DEPTH - 1)) ?
                                                 '0 : r_sh_tail + SPW'(1);
                                    r_sh_fill <= r_sh_fill + SFW'(1);
                                end
                                r_state <= S_DONE;
                            end else if (r_sh_fill == '0) begin
                                r_res_status <= pcrrq_pkg::ST_POP_EMPTY;
                                r_state      <= S_DONE;
                            end else begin
                                r_sh_head <= (r_sh_head == SPW'(SHARED_DEPTH - 1)) ?
                                             '0 : r_sh_head + SPW'(1);
                                r_sh_fill <= r_sh_fill - SFW'(1);
                                r_state   <= S_ENTRY;
                            end
                        end else begin
                            if (i_req.op == pcrrq_pkg::OP_PUSH) begin
                                priority if (hit_any) begin
                                    r_state <= S_LANE;
                                end else if (lanes_full) begin
                                    r_res_status <= pcrrq_pkg::ST_NO_LANE;
                                    r_state      <= S_DONE;
                                end else begin
                                    // first sight of this client takes the next lane
                                    r_tag[r_lane_cnt[LW-1:0]] <= i_req.client;
                                    r_lane_cnt <= r_lane_cnt + LCW'(1);
                                    r_new_lane <= 1'b1;
                                    r_state    <= S_LANE;
                                end
                            end else if (!pick_found) begin
                                r_res_status <= pcrrq_pkg::ST_POP_EMPTY;
                                r_state      <= S_DONE;
                            end else begin
                                r_rr_ptr <= (rr_inc == r_lane_cnt) ? '0 : rr_inc[LW-1:0];
                                r_state  <= S_LANE;
                            end
                        end
                    end
                end
                S_LANE: begin
                    if (r_op == pcrrq_pkg::OP_PUSH) begin
                        if (ls_full) begin
                            r_res_status <= pcrrq_pkg::ST_FULL;
                        end else begin
                            r_busy[r_lane] <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        if (ls_fill == LFW'(1)) begin
                            r_busy[r_lane] <= 1'b0;
                        end
                        r_state <= S_ENTRY;
                    end
                end
                S_ENTRY: begin
                    r_res_valid  <= 1'b1;
                    r_res_client <= ent_rdata[EW-1 -: CW];
                    r_res_pay    <= ent_rdata[PAYLOAD_BITS-1:0];
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_o_vld    <= 1'b1;
                        r_o_outv   <= r_res_valid;
                        r_o_client <= r_res_client;
                        r_o_pay    <= pcrrq_pkg::PAYLOAD_W'(r_res_pay);
                        r_o_status <= r_res_status;
                        r_o_empty  <= (r_mode == pcrrq_pkg::MODE_FIFO) ?
                                      (r_sh_fill == '0) : (r_busy == '0);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_o_vld;
    assign o_rsp.out_valid   = r_o_outv;
    assign o_rsp.out_client  = r_o_client;
    assign o_rsp.out_payload = r_o_pay;
    assign o_rsp.now_empty   = r_o_empty;
    assign o_rsp.status      = r_o_status;

endmodule
